// ===== hw/rtl/ppi_pkg.sv =====
// Particle pool integrator package: sizes, operation codes, sequencer states
// and fixed-point helpers. No dependencies.
`default_nettype none
package ppi_pkg;
    localparam int SLOT_COUNT = 64;
    localparam int SLOT_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int CNT_W      = $clog2(SLOT_COUNT + 1);

    typedef enum logic [1:0] {
        OP_EMIT  = 2'd0,
        OP_TICK  = 2'd1,
        OP_CLEAR = 2'd2,
        OP_QUERY = 2'd3
    } op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_WRITE,
        ST_T_SCAN,
        ST_T_READ,
        ST_T_VY,
        ST_T_PX,
        ST_T_PY,
        ST_T_PZ,
        ST_T_WB,
        ST_CLEAR,
        ST_DONE
    } state_t;

    function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b,
                                            input logic sub);
        logic [32:0] s;
        begin
            s = sub ? ({a[31], a} - {b[31], b}) : ({a[31], a} + {b[31], b});
            if (s[32] != s[31])
                sat_add = s[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
            else
                sat_add = s[31:0];
        end
    endfunction
endpackage
`default_nettype wire

// ===== hw/rtl/particle_pool_integrator.sv =====
// Particle pool integrator top level: sequencer, slot memory and shared
// multiply/saturating-add unit. Depends on ppi_pkg.
`default_nettype none
// One item is taken when start is high and busy is low. Busy then stays high
// up to and including the cycle in which the single result appears, marked by
// done for one cycle; the receiver cannot stall it. An emit searches from
// start_slot for a free slot, skipping each occupied one, and overwrites the
// search start when the pool is full. A tick scans every slot and updates each
// active one in turn: the single multiplier is shared by the four velocity and
// position updates of each slot, the saturating adder also by the lifetime
// update, and the slot store has one read and one write port.
module particle_pool_integrator (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire logic [1:0]            operation,
    input  wire logic [5:0]            start_slot,
    input  wire logic signed [31:0]    pos_x,
    input  wire logic signed [31:0]    pos_y,
    input  wire logic signed [31:0]    pos_z,
    input  wire logic signed [31:0]    vel_x,
    input  wire logic signed [31:0]    vel_y,
    input  wire logic signed [31:0]    vel_z,
    input  wire logic signed [31:0]    lifetime,
    input  wire logic signed [31:0]    fall_accel,
    input  wire logic [15:0]           time_step,
    output logic                       done,
    output logic [5:0]                 slot_used,
    output logic                       overwrote,
    output logic [6:0]                 active_total
);
    import ppi_pkg::*;

    state_t state_reg, state_next;
    logic [SLOT_COUNT-1:0] mark_reg;
    logic [CNT_W-1:0]      count_reg;
    logic [SLOT_W-1:0]     idx_reg, start_reg;
    logic [SLOT_W:0]       steps_reg;
    logic [15:0]           dt_reg;
    logic [255:0]          item_reg;
    logic                  over_reg;

    // slot record: px py pz vx vy vz life accel, 32 bits each
    logic [255:0] mem [SLOT_COUNT];
    logic [255:0] rec_reg;
    logic [31:0]  prod_reg;
    logic         mem_we;

    logic [SLOT_W-1:0] start_mod;
    logic [SLOT_W:0]   wrap_sum;
    assign wrap_sum  = {1'b0, idx_reg} + 1'b1;
    assign start_mod = SLOT_W'({26'd0, start_slot} % SLOT_COUNT);

    logic [SLOT_W-1:0] idx_inc;
    assign idx_inc = (wrap_sum == (SLOT_W+1)'(SLOT_COUNT)) ? '0 : wrap_sum[SLOT_W-1:0];

    // shared multiplier operand
    logic [31:0] mul_a;
    logic signed [48:0] mul_p;
    always_comb
    begin
        unique case (state_reg)
            ST_T_READ: mul_a = rec_reg[31:0];       // accel
            ST_T_VY:   mul_a = rec_reg[159:128];    // vel_x
            ST_T_PX:   mul_a = rec_reg[127:96];     // new vel_y
            ST_T_PY:   mul_a = rec_reg[95:64];      // vel_z
            default:   mul_a = rec_reg[31:0];
        endcase
    end
    assign mul_p = $signed(mul_a) * $signed({1'b0, dt_reg});

    // shared saturating adder
    logic [31:0] add_a, add_b, add_s;
    logic        add_sub;
    always_comb
    begin
        unique case (state_reg)
            ST_T_VY: begin add_a = rec_reg[127:96];  add_b = prod_reg; add_sub = 1'b1; end
            ST_T_PX: begin add_a = rec_reg[255:224]; add_b = prod_reg; add_sub = 1'b0; end
            ST_T_PY: begin add_a = rec_reg[223:192]; add_b = prod_reg; add_sub = 1'b0; end
            ST_T_PZ: begin add_a = rec_reg[191:160]; add_b = prod_reg; add_sub = 1'b0; end
            default: begin add_a = rec_reg[63:32];   add_b = {16'd0, dt_reg}; add_sub = 1'b1; end
        endcase
    end
    assign add_s = sat_add(add_a, add_b, add_sub);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (start)
                begin
                    unique case (op_t'(operation))
                        OP_EMIT:  state_next = ST_SEARCH;
                        OP_TICK:  state_next = ST_T_SCAN;
                        OP_CLEAR: state_next = ST_CLEAR;
                        OP_QUERY: state_next = ST_DONE;
                    endcase
                end
            ST_SEARCH:
                if (!mark_reg[idx_reg] || steps_reg == (SLOT_W+1)'(SLOT_COUNT - 1))
                    state_next = ST_WRITE;
            ST_WRITE:  state_next = ST_DONE;
            ST_T_SCAN:
                if (mark_reg[idx_reg])
                    state_next = ST_T_READ;
                else if (steps_reg == (SLOT_W+1)'(SLOT_COUNT - 1))
                    state_next = ST_DONE;
            ST_T_READ: state_next = ST_T_VY;
            ST_T_VY:   state_next = ST_T_PX;
            ST_T_PX:   state_next = ST_T_PY;
            ST_T_PY:   state_next = ST_T_PZ;
            ST_T_PZ:   state_next = ST_T_WB;
            ST_T_WB:
                state_next = (steps_reg == (SLOT_W+1)'(SLOT_COUNT - 1)) ? ST_DONE : ST_T_SCAN;
            ST_CLEAR:  state_next = ST_DONE;
            ST_DONE:   state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        busy   = (state_reg != ST_IDLE);
        done   = (state_reg == ST_DONE);
        mem_we = (state_reg == ST_WRITE) || (state_reg == ST_T_WB);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            mark_reg  <= '0;
            count_reg <= '0;
            idx_reg   <= '0;
            steps_reg <= '0;
            over_reg  <= 1'b0;
            start_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            unique case (state_reg)
                ST_IDLE:
                    if (start)
                    begin
                        over_reg  <= 1'b0;
                        steps_reg <= '0;
                        start_reg <= '0;
                        idx_reg   <= (op_t'(operation) == OP_EMIT) ? start_mod : '0;
                    end
                ST_SEARCH:
                    if (!mark_reg[idx_reg])
                        start_reg <= idx_reg;
                    else if (steps_reg == (SLOT_W+1)'(SLOT_COUNT - 1))
                    begin
                        // pool full: fall back to the search start
                        over_reg  <= 1'b1;
                        start_reg <= idx_inc;
                    end
                    else
                    begin
                        idx_reg   <= idx_inc;
                        steps_reg <= steps_reg + 1'b1;
                    end
                ST_WRITE:
                begin
                    mark_reg[start_reg] <= 1'b1;
                    if (!over_reg)
                        count_reg <= count_reg + 1'b1;
                end
                ST_T_SCAN:
                    if (!mark_reg[idx_reg])
                    begin
                        idx_reg   <= idx_inc;
                        steps_reg <= steps_reg + 1'b1;
                    end
                ST_T_WB:
                begin
                    if (add_s[31] || add_s == '0)
                    begin
                        mark_reg[idx_reg] <= 1'b0;
                        count_reg         <= count_reg - 1'b1;
                    end
                    idx_reg   <= idx_inc;
                    steps_reg <= steps_reg + 1'b1;
                end
                ST_CLEAR:
                begin
                    mark_reg  <= '0;
                    count_reg <= '0;
                end
                default: ;
            endcase
        end
    end

    // payload and datapath registers
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && start)
        begin
            dt_reg   <= time_step;
            item_reg <= {pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, lifetime, fall_accel};
        end
        // floor of product >> 16
        prod_reg <= mul_p[47:16];
        unique case (state_reg)
            ST_T_VY: rec_reg[127:96]  <= add_s;
            ST_T_PX: rec_reg[255:224] <= add_s;
            ST_T_PY: rec_reg[223:192] <= add_s;
            ST_T_PZ: rec_reg[191:160] <= add_s;
            ST_T_WB: ;
            default: rec_reg <= mem[idx_reg];
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            if (state_reg == ST_WRITE)
                mem[start_reg] <= item_reg;
            else
                mem[idx_reg] <= {rec_reg[255:64], add_s, rec_reg[31:0]};
        end
    end

    always_comb
    begin
        slot_used    = 6'(start_reg);
        overwrote    = over_reg;
        active_total = 7'(count_reg);
    end
endmodule
`default_nettype wire

// ===== hw/rtl/ppi_checker.sv =====
// Port-level checker for the particle pool integrator, bound to the top level.
// Depends on ppi_pkg.
`default_nettype none
module ppi_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       start,
    input wire logic       busy,
    input wire logic       done,
    input wire logic       overwrote,
    input wire logic [6:0] active_total
);
    import ppi_pkg::*;

    // take a transfer only when idle, then report busy
    a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy) else $error("busy not raised");
    a_done_ends_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !busy) else $error("busy after done");
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy) else $error("done while idle");
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (active_total <= 7'(SLOT_COUNT))) else $error("count too large");
    a_over_full: assert property (@(posedge clk) disable iff (!rst_n)
        (done && overwrote) |-> (active_total == 7'(SLOT_COUNT)))
        else $error("overwrite with free slot");
endmodule

bind particle_pool_integrator ppi_checker u_ppi_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .done(done),
    .overwrote(overwrote), .active_total(active_total)
);
`default_nettype wire

// ===== tb/sv/tb_particle_pool_integrator.sv =====
// Self-checking testbench for particle_pool_integrator: directed and random
// emit/tick/clear/query transfers, checked against an in-bench pool predictor.
// Depends on ppi_pkg and the particle_pool_integrator RTL.
module tb_particle_pool_integrator;
    import ppi_pkg::*;

    typedef struct {
        op_t               op;
        logic [5:0]        slot;
        logic signed [31:0] px, py, pz, vx, vy, vz, life, accel;
        logic [15:0]       dt;
        bit                drain;   // wait for every outstanding result first
    } cmd_t;

    typedef struct {
        logic [5:0] slot;
        logic       over;
        logic [6:0] total;
    } res_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy, done, overwrote;
    logic [1:0] operation = '0;
    logic [5:0] start_slot = '0, slot_used;
    logic signed [31:0] pos_x = '0, pos_y = '0, pos_z = '0;
    logic signed [31:0] vel_x = '0, vel_y = '0, vel_z = '0;
    logic signed [31:0] lifetime = '0, fall_accel = '0;
    logic [15:0] time_step = '0;
    logic [6:0] active_total;

    cmd_t cmd_queue[$];
    res_t result_queue[$];
    cmd_t cur_cmd;
    int   n_accepted = 0;
    int   n_errors = 0;
    int   idle_pct = 0;
    bit   stim_done = 0;

    // shadow pool
    bit                 pool_live[SLOT_COUNT];
    logic signed [31:0] pool_px[SLOT_COUNT], pool_py[SLOT_COUNT], pool_pz[SLOT_COUNT];
    logic signed [31:0] pool_vx[SLOT_COUNT], pool_vy[SLOT_COUNT], pool_vz[SLOT_COUNT];
    logic signed [31:0] pool_life[SLOT_COUNT], pool_accel[SLOT_COUNT];
    int                 live_count = 0;

    particle_pool_integrator dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .operation(operation), .start_slot(start_slot),
        .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
        .vel_x(vel_x), .vel_y(vel_y), .vel_z(vel_z),
        .lifetime(lifetime), .fall_accel(fall_accel), .time_step(time_step),
        .done(done), .slot_used(slot_used), .overwrote(overwrote),
        .active_total(active_total)
    );

    always #4 clk = ~clk;

    // floor(a * dt / 2^16)
    function automatic logic signed [63:0] scaled(logic signed [31:0] a, logic [15:0] dt);
        logic signed [63:0] p;
        begin
            p = 64'(a) * $signed({48'd0, dt});
            return p >>> 16;
        end
    endfunction

    function automatic logic signed [31:0] clamp32(logic signed [63:0] v);
        begin
            if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
            if (v < -64'sd2147483648) return 32'h8000_0000;
            return v[31:0];
        end
    endfunction

    task automatic apply_cmd(cmd_t c);
        res_t r;
        int   pick;
        bit   found;
        begin
            r = '{slot: '0, over: 1'b0, total: '0};
            case (c.op)
                OP_EMIT: begin
                    pick = c.slot % SLOT_COUNT;
                    found = 0;
                    for (int i = 0; i < SLOT_COUNT; i++) begin
                        if (!found && !pool_live[(c.slot + i) % SLOT_COUNT]) begin
                            pick = (c.slot + i) % SLOT_COUNT;
                            found = 1;
                        end
                    end
                    if (found) live_count++;
                    else r.over = 1'b1;
                    pool_live[pick] = 1;
                    pool_px[pick] = c.px; pool_py[pick] = c.py; pool_pz[pick] = c.pz;
                    pool_vx[pick] = c.vx; pool_vy[pick] = c.vy; pool_vz[pick] = c.vz;
                    pool_life[pick] = c.life; pool_accel[pick] = c.accel;
                    r.slot = pick[5:0];
                end
                OP_TICK: begin
                    for (int i = 0; i < SLOT_COUNT; i++) begin
                        if (pool_live[i]) begin
                            // velocity first, then position uses the new vel_y
                            pool_vy[i] = clamp32(64'(pool_vy[i]) - scaled(pool_accel[i], c.dt));
                            pool_px[i] = clamp32(64'(pool_px[i]) + scaled(pool_vx[i], c.dt));
                            pool_py[i] = clamp32(64'(pool_py[i]) + scaled(pool_vy[i], c.dt));
                            pool_pz[i] = clamp32(64'(pool_pz[i]) + scaled(pool_vz[i], c.dt));
                            pool_life[i] = clamp32(64'(pool_life[i]) - $signed({48'd0, c.dt}));
                            if (pool_life[i] <= 0) begin
                                pool_live[i] = 0;
                                live_count--;
                            end
                        end
                    end
                end
                OP_CLEAR: begin
                    foreach (pool_live[i]) pool_live[i] = 0;
                    live_count = 0;
                end
                default: ;
            endcase
            r.total = live_count[6:0];
            result_queue.push_back(r);
        end
    endtask

    // driver: one transfer per start && !busy edge
    always @(posedge clk) begin
        bit took;
        took = 0;
        if (rst_n) begin
            if (start && !busy) begin
                apply_cmd(cur_cmd);
                n_accepted++;
                took = 1;
                case (n_accepted * 4 / 1250)
                    0: idle_pct = 0;
                    1: idle_pct = 61;
                    2: idle_pct = 0;
                    default: idle_pct = 37;
                endcase
            end
            if (!start || took) begin
                if (cmd_queue.size() > 0 && $urandom_range(99) >= idle_pct
                    && !(cmd_queue[0].drain && result_queue.size() != 0)) begin
                    cur_cmd = cmd_queue.pop_front();
                    start <= 1'b1;
                    operation <= cur_cmd.op;
                    start_slot <= cur_cmd.slot;
                    pos_x <= cur_cmd.px; pos_y <= cur_cmd.py; pos_z <= cur_cmd.pz;
                    vel_x <= cur_cmd.vx; vel_y <= cur_cmd.vy; vel_z <= cur_cmd.vz;
                    lifetime <= cur_cmd.life;
                    fall_accel <= cur_cmd.accel;
                    time_step <= cur_cmd.dt;
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge clk) begin
        res_t want;
        if (rst_n && done) begin
            if (result_queue.size() == 0) begin
                $error("result with nothing outstanding: slot_used %0d active_total %0d",
                       slot_used, active_total);
                n_errors++;
            end else begin
                want = result_queue.pop_front();
                if (slot_used !== want.slot) begin
                    $error("slot_used: expected %0d, got %0d", want.slot, slot_used);
                    n_errors++;
                end
                if (overwrote !== want.over) begin
                    $error("overwrote: expected %0d, got %0d", want.over, overwrote);
                    n_errors++;
                end
                if (active_total !== want.total) begin
                    $error("active_total: expected %0d, got %0d", want.total, active_total);
                    n_errors++;
                end
            end
        end
    end

    function automatic logic signed [31:0] pick_word();
        case ($urandom_range(9))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2, 3: return $urandom();
            default: return $signed(32'($urandom_range(32'h0020_0000))) - 32'sh0010_0000;
        endcase
    endfunction

    function automatic cmd_t make_cmd(op_t op);
        cmd_t c;
        begin
            c.op = op;
            c.slot = $urandom_range(63);
            c.px = pick_word(); c.py = pick_word(); c.pz = pick_word();
            c.vx = pick_word(); c.vy = pick_word(); c.vz = pick_word();
            c.accel = pick_word();
            // keep most particles alive for a handful of ticks
            if ($urandom_range(9) < 8) c.life = $urandom_range(32'h0008_0000, 1);
            else c.life = $urandom();
            c.dt = ($urandom_range(3) == 0) ? 16'($urandom()) : 16'($urandom_range(16'h2000));
            c.drain = 0;
            return c;
        end
    endfunction

    initial begin
        cmd_t c;
        int   n;
        foreach (pool_live[i]) pool_live[i] = 0;

        // directed: extremes, lifetime edge cases, saturation, every operation
        c = make_cmd(OP_QUERY); cmd_queue.push_back(c);
        c = make_cmd(OP_EMIT); c.slot = 6'd63; c.px = 32'h7FFF_0000;
        c.vx = 32'h7FFF_FFFF; c.vy = 32'h8000_0000; c.accel = 32'h7FFF_FFFF;
        c.py = 32'h8000_0000; c.vz = 32'h8000_0000; c.pz = 32'h8000_0000;
        c.life = 32'h7FFF_FFFF; cmd_queue.push_back(c);
        c = make_cmd(OP_EMIT); c.slot = 6'd63; c.life = 32'sd0; cmd_queue.push_back(c);
        c = make_cmd(OP_EMIT); c.slot = 6'd0; c.life = 32'h8000_0000;
        c.accel = 32'h8000_0000; cmd_queue.push_back(c);
        c = make_cmd(OP_EMIT); c.slot = 6'd0; c.life = 32'sd1; cmd_queue.push_back(c);
        c = make_cmd(OP_TICK); c.dt = 16'd0; cmd_queue.push_back(c);
        c = make_cmd(OP_TICK); c.dt = 16'hFFFF; cmd_queue.push_back(c);
        c = make_cmd(OP_TICK); c.dt = 16'hFFFF; cmd_queue.push_back(c);
        c = make_cmd(OP_QUERY); c.drain = 1; cmd_queue.push_back(c);
        c = make_cmd(OP_CLEAR); cmd_queue.push_back(c);
        c = make_cmd(OP_EMIT); c.slot = 6'd31; cmd_queue.push_back(c);
        c = make_cmd(OP_CLEAR); cmd_queue.push_back(c);

        // random: emit bursts to fill the pool, ticks to age it
        while (cmd_queue.size() < 1250) begin
            case ($urandom_range(19))
                0: c = make_cmd(OP_CLEAR);
                1, 2: c = make_cmd(OP_QUERY);
                3, 4, 5, 6, 7: c = make_cmd(OP_TICK);
                8: begin
                    n = $urandom_range(72, 20);
                    repeat (n) cmd_queue.push_back(make_cmd(OP_EMIT));
                    c = make_cmd(OP_EMIT);
                end
                default: c = make_cmd(OP_EMIT);
            endcase
            c.drain = ($urandom_range(99) == 0);
            cmd_queue.push_back(c);
        end

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        wait (cmd_queue.size() == 0);
        @(posedge clk);
        wait (!start && result_queue.size() == 0);
        repeat (600) @(posedge clk);
        if (n_errors == 0 && result_queue.size() == 0)
            $display("[particle_pool_integrator] OK");
        else
            $display("[particle_pool_integrator] ERROR");
        $finish;
    end

    initial begin
        #30_000_000;
        $display("[particle_pool_integrator] ERROR");
        $finish;
    end
endmodule
